FILE: src/etok_pkg.sv
// etok_pkg: shared types, token kinds, operator and keyword tables for the tokenizer
package etok_pkg;

   localparam int KIND_BITS  = 5;
   localparam int FIELD_BITS = 16;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_INT,
      MODE_FRAC,
      MODE_WORD,
      MODE_STR,
      MODE_OP,
      MODE_SKIP
   } mode_type;

   localparam logic [KIND_BITS-1:0] KIND_NUM         = 5'd0;
   localparam logic [KIND_BITS-1:0] KIND_STRING      = 5'd1;
   localparam logic [KIND_BITS-1:0] KIND_PLUS        = 5'd2;
   localparam logic [KIND_BITS-1:0] KIND_MINUS       = 5'd3;
   localparam logic [KIND_BITS-1:0] KIND_STAR        = 5'd4;
   localparam logic [KIND_BITS-1:0] KIND_SLASH       = 5'd5;
   localparam logic [KIND_BITS-1:0] KIND_CARET       = 5'd6;
   localparam logic [KIND_BITS-1:0] KIND_LEFT_PAREN  = 5'd7;
   localparam logic [KIND_BITS-1:0] KIND_RIGHT_PAREN = 5'd8;
   localparam logic [KIND_BITS-1:0] KIND_COMMA       = 5'd9;
   localparam logic [KIND_BITS-1:0] KIND_EQUAL       = 5'd10;
   localparam logic [KIND_BITS-1:0] KIND_DOLLAR      = 5'd11;
   localparam logic [KIND_BITS-1:0] KIND_ANS         = 5'd12;
   localparam logic [KIND_BITS-1:0] KIND_IDENT       = 5'd13;
   localparam logic [KIND_BITS-1:0] KIND_LET         = 5'd14;
   localparam logic [KIND_BITS-1:0] KIND_EXIT        = 5'd15;
   localparam logic [KIND_BITS-1:0] KIND_OR          = 5'd16;
   localparam logic [KIND_BITS-1:0] KIND_AND         = 5'd17;
   localparam logic [KIND_BITS-1:0] KIND_EQEQ        = 5'd18;
   localparam logic [KIND_BITS-1:0] KIND_NOT         = 5'd19;
   localparam logic [KIND_BITS-1:0] KIND_NOTEQ       = 5'd20;
   localparam logic [KIND_BITS-1:0] KIND_LESS        = 5'd21;
   localparam logic [KIND_BITS-1:0] KIND_LESSEQ      = 5'd22;
   localparam logic [KIND_BITS-1:0] KIND_GREATER     = 5'd23;
   localparam logic [KIND_BITS-1:0] KIND_GREATEREQ   = 5'd24;
   localparam logic [KIND_BITS-1:0] KIND_TRUE        = 5'd25;
   localparam logic [KIND_BITS-1:0] KIND_FALSE       = 5'd26;
   localparam logic [KIND_BITS-1:0] KIND_END         = 5'd27;
   localparam logic [KIND_BITS-1:0] KIND_ERROR       = 5'd28;

   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_EQ   = 3'd1;
   localparam logic [2:0] OP_BANG = 3'd2;
   localparam logic [2:0] OP_LT   = 3'd3;
   localparam logic [2:0] OP_GT   = 3'd4;
   localparam logic [2:0] OP_AMP  = 3'd5;
   localparam logic [2:0] OP_BAR  = 3'd6;

   localparam logic [2:0] KW_NONE  = 3'd0;
   localparam logic [2:0] KW_ANS   = 3'd1;
   localparam logic [2:0] KW_EXIT  = 3'd2;
   localparam logic [2:0] KW_LET   = 3'd3;
   localparam logic [2:0] KW_TRUE  = 3'd4;
   localparam logic [2:0] KW_FALSE = 3'd5;

   localparam logic [FIELD_BITS-1:0] END_LENGTH = 16'd3;

   typedef struct packed {
      logic [KIND_BITS-1:0]  kind;
      logic [FIELD_BITS-1:0] offset;
      logic [FIELD_BITS-1:0] length;
      logic                  last;
   } result_type;

   typedef struct packed {
      logic       valid0;
      logic       valid1;
      result_type slot0;
      result_type slot1;
   } result_pair_type;

   function automatic logic [KIND_BITS-1:0] op_single_kind(input logic [2:0] op);
      case (op)
         OP_EQ:   return KIND_EQUAL;
         OP_BANG: return KIND_NOT;
         OP_LT:   return KIND_LESS;
         OP_GT:   return KIND_GREATER;
         default: return KIND_ERROR;
      endcase
   endfunction

   function automatic logic [KIND_BITS-1:0] op_double_kind(input logic [2:0] op);
      case (op)
         OP_EQ:   return KIND_EQEQ;
         OP_BANG: return KIND_NOTEQ;
         OP_LT:   return KIND_LESSEQ;
         OP_GT:   return KIND_GREATEREQ;
         OP_AMP:  return KIND_AND;
         default: return KIND_OR;
      endcase
   endfunction

   function automatic logic [7:0] op_second_char(input logic [2:0] op);
      case (op)
         OP_AMP:  return "&";
         OP_BAR:  return "|";
         default: return "=";
      endcase
   endfunction

   function automatic logic [2:0] kw_length(input logic [2:0] kw);
      case (kw)
         KW_ANS:   return 3'd3;
         KW_EXIT:  return 3'd4;
         KW_LET:   return 3'd3;
         KW_TRUE:  return 3'd4;
         KW_FALSE: return 3'd5;
         default:  return 3'd0;
      endcase
   endfunction

   function automatic logic [KIND_BITS-1:0] kw_kind(input logic [2:0] kw);
      case (kw)
         KW_ANS:   return KIND_ANS;
         KW_EXIT:  return KIND_EXIT;
         KW_LET:   return KIND_LET;
         KW_TRUE:  return KIND_TRUE;
         KW_FALSE: return KIND_FALSE;
         default:  return KIND_IDENT;
      endcase
   endfunction

   function automatic logic [7:0] kw_char(input logic [2:0] kw, input logic [2:0] idx);
      logic [39:0] text;
      case (kw)
         KW_ANS:   text = {"ans", 16'h0000};
         KW_EXIT:  text = {"exit", 8'h00};
         KW_LET:   text = {"let", 16'h0000};
         KW_TRUE:  text = {"true", 8'h00};
         KW_FALSE: text = "false";
         default:  text = 40'h0;
      endcase
      case (idx)
         3'd0:    return text[39:32];
         3'd1:    return text[31:24];
         3'd2:    return text[23:16];
         3'd3:    return text[15:8];
         3'd4:    return text[7:0];
         default: return 8'h00;
      endcase
   endfunction

endpackage

FILE: src/etok_lexer.sv
// etok_lexer: lexing state registers and the per-byte next-state and token logic
module etok_lexer #(
   parameter int POSITION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  logic [7:0]               char_code,
   output etok_pkg::result_pair_type push
);
   import etok_pkg::*;

   localparam int PB = POSITION_BITS;

   mode_type        mode_ff, mode_in;
   logic [PB-1:0]   position_ff, position_in;
   logic [PB-1:0]   begin_ff, begin_in;
   logic [2:0]      kw_ff, kw_in;
   logic            match_ff, match_in;
   logic [7:0]      quote_ff, quote_in;
   logic            escape_ff, escape_in;
   logic [2:0]      pend_ff, pend_in;

   logic            a_v, b_v, do_idle;
   result_type      a_res, b_res;
   logic [PB-1:0]   pos_next, len_now;
   logic            char_digit, char_letter, is_blank;

   function automatic logic [PB-1:0] pos_inc(input logic [PB-1:0] p);
      return (p == '1) ? p : p + 1'b1;
   endfunction

   function automatic logic [FIELD_BITS-1:0] sat16(input logic [PB-1:0] v);
      logic [PB+FIELD_BITS-1:0] ext;
      ext = {{FIELD_BITS{1'b0}}, v};
      if (ext[PB+FIELD_BITS-1:FIELD_BITS] != '0) return '1;
      return ext[FIELD_BITS-1:0];
   endfunction

   assign pos_next      = pos_inc(position_ff);
   assign len_now       = (position_ff >= begin_ff) ? position_ff - begin_ff : '0;
   assign char_digit    = (char_code >= "0") && (char_code <= "9");
   assign char_letter   = ((char_code >= "a") && (char_code <= "z")) ||
                          ((char_code >= "A") && (char_code <= "Z"));
   assign is_blank      = (char_code == " ") || (char_code == 8'h0A) ||
                          (char_code == 8'h09) || (char_code == 8'h0D);

   always_comb begin
      mode_in     = mode_ff;
      position_in = position_ff;
      begin_in    = begin_ff;
      kw_in       = kw_ff;
      match_in    = match_ff;
      quote_in    = quote_ff;
      escape_in   = escape_ff;
      pend_in     = pend_ff;
      a_v         = 1'b0;
      a_res       = '0;
      b_v         = 1'b0;
      b_res       = '0;
      do_idle     = 1'b0;

      // token in progress
      case (mode_ff)
         MODE_INT: begin
            if (char_digit) begin
               position_in = pos_next;
            end else if (char_code == ".") begin
               mode_in     = MODE_FRAC;
               position_in = pos_next;
            end else begin
               a_v     = 1'b1;
               a_res   = '{KIND_NUM, sat16(begin_ff), sat16(len_now), 1'b0};
               do_idle = 1'b1;
            end
         end
         MODE_FRAC: begin
            if (char_digit) begin
               position_in = pos_next;
            end else begin
               a_v     = 1'b1;
               a_res   = '{KIND_NUM, sat16(begin_ff), sat16(len_now), 1'b0};
               do_idle = 1'b1;
            end
         end
         MODE_WORD: begin
            if (char_letter || char_digit) begin
               if (match_ff && ((len_now >= PB'(kw_length(kw_ff))) ||
                                (kw_char(kw_ff, len_now[2:0]) != char_code))) begin
                  match_in = 1'b0;
               end
               position_in = pos_next;
            end else begin
               a_v   = 1'b1;
               a_res = '{KIND_IDENT, sat16(begin_ff), sat16(len_now), 1'b0};
               if (kw_ff != KW_NONE && match_ff && len_now == PB'(kw_length(kw_ff))) begin
                  a_res.kind = kw_kind(kw_ff);
               end
               kw_in    = KW_NONE;
               match_in = 1'b0;
               do_idle  = 1'b1;
            end
         end
         MODE_STR: begin
            if (char_code == 8'h00) begin
               a_v         = 1'b1;
               a_res       = '{KIND_ERROR, sat16(begin_ff), sat16(len_now), 1'b0};
               mode_in     = MODE_IDLE;
               position_in = '0;
               begin_in    = '0;
               kw_in       = KW_NONE;
               match_in    = 1'b0;
               quote_in    = 8'h00;
               escape_in   = 1'b0;
               pend_in     = OP_NONE;
            end else if (escape_ff) begin
               escape_in   = 1'b0;
               position_in = pos_next;
            end else if (char_code == quote_ff) begin
               a_v         = 1'b1;
               a_res       = '{KIND_STRING, sat16(begin_ff), sat16(len_now), 1'b0};
               position_in = pos_next;
               quote_in    = 8'h00;
               mode_in     = MODE_IDLE;
            end else begin
               if (char_code == "\\") escape_in = 1'b1;
               position_in = pos_next;
            end
         end
         MODE_OP: begin
            pend_in = OP_NONE;
            if (pend_ff != OP_NONE && char_code == op_second_char(pend_ff)) begin
               a_v         = 1'b1;
               a_res       = '{op_double_kind(pend_ff), sat16(begin_ff), 16'd2, 1'b0};
               position_in = pos_next;
               mode_in     = MODE_IDLE;
            end else begin
               a_v     = (pend_ff != OP_NONE);
               a_res   = '{op_single_kind(pend_ff), sat16(begin_ff), 16'd1, 1'b0};
               do_idle = 1'b1;
            end
         end
         MODE_SKIP: begin
            if (char_code == 8'h00) begin
               a_v         = 1'b1;
               a_res       = '{KIND_ERROR, sat16(begin_ff), sat16(len_now), 1'b0};
               mode_in     = MODE_IDLE;
               position_in = '0;
               begin_in    = '0;
               kw_in       = KW_NONE;
               match_in    = 1'b0;
               quote_in    = 8'h00;
               escape_in   = 1'b0;
               pend_in     = OP_NONE;
            end else begin
               position_in = pos_next;
            end
         end
         default: begin
            do_idle = 1'b1;
         end
      endcase

      // byte seen between tokens
      if (do_idle) begin
         mode_in = MODE_IDLE;
         if (char_code == 8'h00) begin
            b_v         = 1'b1;
            b_res       = '{KIND_END, sat16(position_ff), END_LENGTH, 1'b0};
            position_in = '0;
            begin_in    = '0;
            kw_in       = KW_NONE;
            match_in    = 1'b0;
            quote_in    = 8'h00;
            escape_in   = 1'b0;
            pend_in     = OP_NONE;
         end else begin
            position_in = pos_next;
            if (!is_blank) begin
               begin_in = position_ff;
               b_res    = '{KIND_ERROR, sat16(position_ff), 16'd1, 1'b0};
               if (char_digit) begin
                  mode_in = MODE_INT;
               end else begin
                  case (char_code)
                     "'", "\"": begin
                        quote_in  = char_code;
                        escape_in = 1'b0;
                        begin_in  = pos_next;
                        mode_in   = MODE_STR;
                     end
                     "+": begin b_v = 1'b1; b_res.kind = KIND_PLUS; end
                     "-": begin b_v = 1'b1; b_res.kind = KIND_MINUS; end
                     "*": begin b_v = 1'b1; b_res.kind = KIND_STAR; end
                     "/": begin b_v = 1'b1; b_res.kind = KIND_SLASH; end
                     "^": begin b_v = 1'b1; b_res.kind = KIND_CARET; end
                     "(": begin b_v = 1'b1; b_res.kind = KIND_LEFT_PAREN; end
                     ")": begin b_v = 1'b1; b_res.kind = KIND_RIGHT_PAREN; end
                     ",": begin b_v = 1'b1; b_res.kind = KIND_COMMA; end
                     "$": begin b_v = 1'b1; b_res.kind = KIND_DOLLAR; end
                     "=": begin pend_in = OP_EQ;   mode_in = MODE_OP; end
                     "!": begin pend_in = OP_BANG; mode_in = MODE_OP; end
                     "<": begin pend_in = OP_LT;   mode_in = MODE_OP; end
                     ">": begin pend_in = OP_GT;   mode_in = MODE_OP; end
                     "&": begin pend_in = OP_AMP;  mode_in = MODE_OP; end
                     "|": begin pend_in = OP_BAR;  mode_in = MODE_OP; end
                     "a": begin kw_in = KW_ANS;   match_in = 1'b1; mode_in = MODE_WORD; end
                     "e": begin kw_in = KW_EXIT;  match_in = 1'b1; mode_in = MODE_WORD; end
                     "l": begin kw_in = KW_LET;   match_in = 1'b1; mode_in = MODE_WORD; end
                     "t": begin kw_in = KW_TRUE;  match_in = 1'b1; mode_in = MODE_WORD; end
                     "f": begin kw_in = KW_FALSE; match_in = 1'b1; mode_in = MODE_WORD; end
                     default: begin
                        if (char_letter) begin
                           kw_in    = KW_NONE;
                           match_in = 1'b0;
                           mode_in  = MODE_WORD;
                        end else begin
                           mode_in = MODE_SKIP;
                        end
                     end
                  endcase
               end
            end
         end
      end
   end

   // pack results in order, last flag on the final one
   always_comb begin
      push = '0;
      if (a_v) begin
         push.valid0 = 1'b1;
         push.slot0  = a_res;
         push.valid1 = b_v;
         push.slot1  = b_res;
      end else begin
         push.valid0 = b_v;
         push.slot0  = b_res;
      end
      push.slot0.last = !push.valid1;
      push.slot1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         position_ff <= '0;
         begin_ff    <= '0;
         kw_ff       <= KW_NONE;
         match_ff    <= 1'b0;
         quote_ff    <= 8'h00;
         escape_ff   <= 1'b0;
         pend_ff     <= OP_NONE;
      end else if (fire) begin
         mode_ff     <= mode_in;
         position_ff <= position_in;
         begin_ff    <= begin_in;
         kw_ff       <= kw_in;
         match_ff    <= match_in;
         quote_ff    <= quote_in;
         escape_ff   <= escape_in;
         pend_ff     <= pend_in;
      end
   end

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      fire && ((push.valid0 && push.slot0.kind == KIND_END) ||
               (push.valid1 && push.slot1.kind == KIND_END))
      |=> position_ff == '0 && mode_ff == MODE_IDLE)
      else $error("text did not restart after end token");

endmodule

FILE: src/etok_fifo.sv
// etok_fifo: four-word result queue taking up to two words per cycle
module etok_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  etok_pkg::result_pair_type push,
   output logic                      room,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output etok_pkg::result_type      head
);
   import etok_pkg::*;

   result_type  store_ff [4];
   logic [2:0]  count_ff, count_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  push_n;
   logic        pop;

   assign room      = (count_ff <= 3'd2);
   assign rsp_valid = (count_ff != 3'd0);
   assign head      = store_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign push_n    = fire ? ({1'b0, push.valid0} + {1'b0, push.valid1}) : 2'd0;
   assign count_in  = count_ff + {1'b0, push_n} - {2'b00, pop};
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign wr_ptr_in = wr_ptr_ff + push_n;

   always_ff @(posedge clock) begin
      if (fire && push.valid0) store_ff[wr_ptr_ff] <= push.slot0;
      if (fire && push.valid1) store_ff[wr_ptr_ff + 2'd1] <= push.slot1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 3'd0;
         rd_ptr_ff <= 2'd0;
         wr_ptr_ff <= 2'd0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue overflow");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      fire |-> room)
      else $error("push without room for two words");

   a_ordered_push: assert property (@(posedge clock) disable iff (reset)
      fire && push.valid1 |-> push.valid0 && !push.slot0.last)
      else $error("second word pushed without first");

endmodule

FILE: src/expression_tokenizer.sv
// expression_tokenizer: streaming tokenizer top level with input register and result queue
// a held byte is lexed once the queue has room; its tokens are queued, then shown on rsp
// throughput: one byte per cycle unless held back; a byte that closes a token and starts
//    an emitting one yields two words, leaving the four-word queue one per rsp_ready cycle
// input is held back while the queue has fewer than two free words
// reset (synchronous, active high) empties the queue and returns to offset 0, idle mode
module expression_tokenizer #(
   parameter int POSITION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_char_code,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [etok_pkg::KIND_BITS-1:0]      rsp_token_kind,
   output logic [etok_pkg::FIELD_BITS-1:0]     rsp_token_offset,
   output logic [etok_pkg::FIELD_BITS-1:0]     rsp_token_length,
   output logic                                rsp_last_of_run
);
   import etok_pkg::*;

   // input register: one byte waiting for the lexer
   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_char_ff;
   logic            fire;
   logic            room;
   result_pair_type push;
   result_type      head;

   // the lexer consumes the held byte whenever the queue can take two words
   assign fire        = in_valid_ff && room;
   assign req_ready   = !in_valid_ff || fire;
   assign in_valid_in = (req_valid && req_ready) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_char_ff <= req_char_code;
   end

   // mode, position and token tracking
   etok_lexer #(
      .POSITION_BITS(POSITION_BITS)
   ) u_lexer (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .char_code (in_char_ff),
      .push      (push)
   );

   // result queue decouples two-word bytes from the output handshake
   etok_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_offset = head.offset;
   assign rsp_token_length = head.length;
   assign rsp_last_of_run  = head.last;

   a_held_byte_stable: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(in_char_ff))
      else $error("held input byte lost while queue full");

endmodule

FILE: verif/tb_expression_tokenizer.sv
// tb_expression_tokenizer: self-checking bench for the streaming expression tokenizer
module tb_expression_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;

   import etok_pkg::*;

   // run shape
   localparam int RANDOM_BYTES = 1410;  // random part stops once this many bytes are queued
   localparam int HOLD_AT      = 700;   // accepted bytes before the long receiver hold-off
   localparam int HOLD_CYCLES  = 300;   // length of that hold-off
   localparam int QUIET_LIMIT  = 2000;  // cycles with no word moving on either side
   localparam int TAIL_CYCLES  = 16;    // settle time after the last expected word

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #10ns clock = ~clock;

   // block ports, all inputs known from time zero
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_char_code = 8'd0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [KIND_BITS-1:0]  rsp_token_kind;
   logic [FIELD_BITS-1:0] rsp_token_offset;
   logic [FIELD_BITS-1:0] rsp_token_length;
   logic                  rsp_last_of_run;

   expression_tokenizer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_offset (rsp_token_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   // ------------------------------------------------------------------
   // lexer mirror: state kept in step with the block, one byte at a time
   // ------------------------------------------------------------------
   mode_type              lex_state;
   logic [FIELD_BITS-1:0] lex_pos;
   logic [FIELD_BITS-1:0] tok_start;
   logic [2:0]            kw_pick;
   logic                  kw_alive;
   logic [7:0]            open_quote;
   logic                  after_backslash;
   logic [2:0]            op_held;

   // keyword spellings and kinds, indexed by the KW_ codes
   string kw_spelling [0:5] = '{"", "ans", "exit", "let", "true", "false"};
   logic [KIND_BITS-1:0] kw_token [0:5] =
      '{KIND_IDENT, KIND_ANS, KIND_EXIT, KIND_LET, KIND_TRUE, KIND_FALSE};

   // two-byte operator tables, indexed by the OP_ codes
   logic [KIND_BITS-1:0] op_alone [0:6] =
      '{KIND_ERROR, KIND_EQUAL, KIND_NOT, KIND_LESS, KIND_GREATER, KIND_ERROR, KIND_ERROR};
   logic [KIND_BITS-1:0] op_pair [0:6] =
      '{KIND_ERROR, KIND_EQEQ, KIND_NOTEQ, KIND_LESSEQ, KIND_GREATEREQ, KIND_AND, KIND_OR};
   logic [7:0] op_follow [0:6] = '{8'd0, "=", "=", "=", "=", "&", "|"};

   result_type step_words [$];   // tokens caused by the byte being lexed
   result_type tokens_due [$];   // words still owed by the block, oldest first

   function automatic logic is_numeral(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == " " || c == "\n" || c == "\t" || c == "\r";
   endfunction

   // offsets stop at the top of the position range
   function automatic logic [FIELD_BITS-1:0] advance(logic [FIELD_BITS-1:0] p);
      return (p == '1) ? p : p + 1'b1;
   endfunction

   function automatic logic [FIELD_BITS-1:0] span(logic [FIELD_BITS-1:0] p);
      return (p >= tok_start) ? p - tok_start : '0;
   endfunction

   function automatic void add_token(logic [KIND_BITS-1:0] kind,
                                     logic [FIELD_BITS-1:0] off,
                                     logic [FIELD_BITS-1:0] len);
      result_type w;
      w.kind   = kind;
      w.offset = off;
      w.length = len;
      w.last   = 1'b0;
      step_words.push_back(w);
   endfunction

   function automatic void reset_lexer();
      lex_state       = MODE_IDLE;
      lex_pos         = '0;
      tok_start       = '0;
      kw_pick         = KW_NONE;
      kw_alive        = 1'b0;
      open_quote      = 8'd0;
      after_backslash = 1'b0;
      op_held         = OP_NONE;
   endfunction

   // a byte seen between tokens: may end the text, emit a one-byte token or open a new one
   function automatic void lex_fresh(logic [7:0] c);
      logic [FIELD_BITS-1:0] p;
      p = lex_pos;
      lex_state = MODE_IDLE;
      if (c == 8'd0) begin
         add_token(KIND_END, p, END_LENGTH);
         reset_lexer();
         return;
      end
      lex_pos = advance(p);
      if (is_blank(c)) return;
      tok_start = p;
      if (is_numeral(c)) begin
         lex_state = MODE_INT;
         return;
      end
      case (c)
         "'", "\"": begin
            // string offset points past the opening quote
            open_quote      = c;
            after_backslash = 1'b0;
            tok_start       = advance(p);
            lex_state       = MODE_STR;
            return;
         end
         "+": begin add_token(KIND_PLUS, p, 16'd1); return; end
         "-": begin add_token(KIND_MINUS, p, 16'd1); return; end
         "*": begin add_token(KIND_STAR, p, 16'd1); return; end
         "/": begin add_token(KIND_SLASH, p, 16'd1); return; end
         "^": begin add_token(KIND_CARET, p, 16'd1); return; end
         "(": begin add_token(KIND_LEFT_PAREN, p, 16'd1); return; end
         ")": begin add_token(KIND_RIGHT_PAREN, p, 16'd1); return; end
         ",": begin add_token(KIND_COMMA, p, 16'd1); return; end
         "$": begin add_token(KIND_DOLLAR, p, 16'd1); return; end
         "=": begin op_held = OP_EQ; lex_state = MODE_OP; return; end
         "!": begin op_held = OP_BANG; lex_state = MODE_OP; return; end
         "<": begin op_held = OP_LT; lex_state = MODE_OP; return; end
         ">": begin op_held = OP_GT; lex_state = MODE_OP; return; end
         "&": begin op_held = OP_AMP; lex_state = MODE_OP; return; end
         "|": begin op_held = OP_BAR; lex_state = MODE_OP; return; end
         "a": kw_pick = KW_ANS;
         "e": kw_pick = KW_EXIT;
         "l": kw_pick = KW_LET;
         "t": kw_pick = KW_TRUE;
         "f": kw_pick = KW_FALSE;
         default: begin
            // anything unknown swallows the rest of the text
            if (!is_letter(c)) begin
               lex_state = MODE_SKIP;
               return;
            end
            kw_pick = KW_NONE;
         end
      endcase
      kw_alive  = (kw_pick != KW_NONE);
      lex_state = MODE_WORD;
   endfunction

   // one accepted byte: queue the words it must produce, last flag on the final one
   function automatic void tokenize_byte(logic [7:0] c);
      logic [FIELD_BITS-1:0] p;
      logic [FIELD_BITS-1:0] len;
      logic [KIND_BITS-1:0]  kind;
      logic [2:0]            op;
      result_type            w;
      p = lex_pos;
      step_words.delete();
      case (lex_state)
         MODE_INT: begin
            if (is_numeral(c)) lex_pos = advance(p);
            else if (c == ".") begin
               lex_state = MODE_FRAC;
               lex_pos   = advance(p);
            end else begin
               add_token(KIND_NUM, tok_start, span(p));
               lex_fresh(c);
            end
         end
         MODE_FRAC: begin
            if (is_numeral(c)) lex_pos = advance(p);
            else begin
               add_token(KIND_NUM, tok_start, span(p));
               lex_fresh(c);
            end
         end
         MODE_WORD: begin
            if (is_letter(c) || is_numeral(c)) begin
               // keyword stays a candidate only while every byte matches its spelling
               len = span(p);
               if (kw_alive && (len >= kw_spelling[kw_pick].len() ||
                                kw_spelling[kw_pick][len] != c))
                  kw_alive = 1'b0;
               lex_pos = advance(p);
            end else begin
               len  = span(p);
               kind = KIND_IDENT;
               if (kw_pick != KW_NONE && kw_alive && len == kw_spelling[kw_pick].len())
                  kind = kw_token[kw_pick];
               add_token(kind, tok_start, len);
               kw_pick  = KW_NONE;
               kw_alive = 1'b0;
               lex_fresh(c);
            end
         end
         MODE_STR: begin
            if (c == 8'd0) begin
               // text ended inside the string
               add_token(KIND_ERROR, tok_start, span(p));
               reset_lexer();
            end else if (after_backslash) begin
               after_backslash = 1'b0;
               lex_pos         = advance(p);
            end else if (c == open_quote) begin
               add_token(KIND_STRING, tok_start, span(p));
               lex_pos    = advance(p);
               open_quote = 8'd0;
               lex_state  = MODE_IDLE;
            end else begin
               if (c == "\\") after_backslash = 1'b1;
               lex_pos = advance(p);
            end
         end
         MODE_OP: begin
            op      = op_held;
            op_held = OP_NONE;
            if (op != OP_NONE && c == op_follow[op]) begin
               add_token(op_pair[op], tok_start, 16'd2);
               lex_pos   = advance(p);
               lex_state = MODE_IDLE;
            end else begin
               // lone & or | comes out as a one-byte error
               if (op != OP_NONE) add_token(op_alone[op], tok_start, 16'd1);
               lex_fresh(c);
            end
         end
         MODE_SKIP: begin
            if (c == 8'd0) begin
               add_token(KIND_ERROR, tok_start, span(p));
               reset_lexer();
            end else lex_pos = advance(p);
         end
         default: lex_fresh(c);
      endcase
      for (int i = 0; i < step_words.size(); i++) begin
         w      = step_words[i];
         w.last = (i == step_words.size() - 1);
         tokens_due.push_back(w);
      end
   endfunction

   // ------------------------------------------------------------------
   // stimulus: texts built up front as a byte queue for the driver
   // ------------------------------------------------------------------
   logic [7:0] pending_chars [$];
   int         total_bytes;

   function automatic void push_char(logic [7:0] c);
      pending_chars.push_back(c);
   endfunction

   function automatic void push_chars(string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endfunction

   function automatic logic [7:0] rand_letter();
      return 8'($urandom_range(0, 1) ? $urandom_range(97, 122) : $urandom_range(65, 90));
   endfunction

   function automatic logic [7:0] rand_alnum();
      return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(48, 57)) : rand_letter();
   endfunction

   // string body: random nonzero bytes, escapes that may hide the quote
   function automatic void push_string_body(logic [7:0] q);
      logic [7:0] c;
      int         n;
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 5) == 0) begin
            push_char("\\");
            push_char(8'($urandom_range(1, 255)));
         end else begin
            c = 8'($urandom_range(1, 255));
            while (c == q || c == "\\") c = 8'($urandom_range(1, 255));
            push_char(c);
         end
      end
   endfunction

   // one random text: mostly well-formed tokens, some noise and broken strings
   function automatic void push_random_text();
      string      blanks;
      string      singles;
      string      pairs;
      string      spell;
      logic [7:0] q;
      logic [7:0] c;
      int         n_tokens;
      int         k;
      int         n;
      blanks   = " \t\r\n";
      singles  = "+-*/^(),$";
      pairs    = "=!<>&|";
      n_tokens = $urandom_range(1, 10);
      for (int t = 0; t < n_tokens; t++) begin
         if ($urandom_range(0, 1)) begin
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++) push_char(blanks[$urandom_range(0, 3)]);
         end
         case ($urandom_range(0, 19))
            0, 1, 2, 3: begin
               n = $urandom_range(1, 6);
               for (int i = 0; i < n; i++) push_char(8'($urandom_range(48, 57)));
               if ($urandom_range(0, 1)) begin
                  push_char(".");
                  n = $urandom_range(0, 4);
                  for (int i = 0; i < n; i++) push_char(8'($urandom_range(48, 57)));
               end
            end
            4, 5: begin
               push_char(rand_letter());
               n = $urandom_range(0, 6);
               for (int i = 0; i < n; i++) push_char(rand_alnum());
            end
            6, 7: begin
               // keyword, or a near miss: cut short, run on, or one byte off
               k     = $urandom_range(1, 5);
               spell = kw_spelling[k];
               case ($urandom_range(0, 3))
                  0: push_chars(spell);
                  1: push_chars(spell.substr(0, $urandom_range(0, spell.len() - 2)));
                  2: begin
                     push_chars(spell);
                     push_char(rand_alnum());
                  end
                  default: begin
                     spell[$urandom_range(0, spell.len() - 1)] = rand_letter();
                     push_chars(spell);
                  end
               endcase
            end
            8, 9: begin
               q = $urandom_range(0, 1) ? "'" : "\"";
               push_char(q);
               push_string_body(q);
               push_char(q);
            end
            10, 11, 12, 13: push_char(singles[$urandom_range(0, singles.len() - 1)]);
            14, 15, 16: begin
               c = pairs[$urandom_range(0, pairs.len() - 1)];
               push_char(c);
               if ($urandom_range(0, 1)) push_char((c == "&" || c == "|") ? c : 8'("="));
            end
            17: push_char(8'($urandom_range(1, 255)));
            default: begin
               // string left open, sometimes right after a backslash
               q = $urandom_range(0, 1) ? "'" : "\"";
               push_char(q);
               push_string_body(q);
               if ($urandom_range(0, 1)) push_char("\\");
               push_char(8'd0);
               return;
            end
         endcase
      end
      push_char(8'd0);
   endfunction

   function automatic void build_stimulus();
      int start;
      // directed: keyword, name, fraction, comma, escaped quote, lone &, end of text
      push_chars("let a1=2.5,\"q\\\"z\"&b");
      push_char(8'd0);
      push_char(8'd0);                          // empty text: END at offset 0
      push_char(8'hFF);                         // unknown bytes with the top bit set
      push_char(8'h80);
      push_char(8'd0);
      push_chars("'ab");                        // open string at end of text
      push_char(8'd0);
      start = pending_chars.size();
      while (pending_chars.size() - start < RANDOM_BYTES) push_random_text();
      total_bytes = pending_chars.size();
   endfunction

   // ------------------------------------------------------------------
   // driver: bursts of offered bytes with random gaps, model updated on accept
   // ------------------------------------------------------------------
   int bytes_accepted = 0;
   int texts_done     = 0;
   int burst_left     = 0;
   int gap_left       = 0;

   always @(posedge clock) begin
      logic       offer;
      logic [7:0] next_char;
      offer     = 1'b0;
      next_char = 8'd0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            tokenize_byte(req_char_code);
            bytes_accepted <= bytes_accepted + 1;
            if (req_char_code == 8'd0) texts_done <= texts_done + 1;
         end
         // a word still waiting keeps valid and data as they are
         if (!req_valid || req_ready) begin
            if (gap_left > 0) gap_left--;
            else if (pending_chars.size() > 0) begin
               offer     = 1'b1;
               next_char = pending_chars.pop_front();
               if (burst_left > 1) burst_left--;
               else begin
                  // now and then a long burst with no gaps at all
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
            req_valid <= offer;
            if (offer) req_char_code <= next_char;
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver: changing stall styles plus one long hold-off that backs up the block
   // ------------------------------------------------------------------
   int   stall_style  = 0;
   int   pattern_left = 0;
   int   hold_left    = 0;
   logic hold_done    = 1'b0;

   always @(posedge clock) begin
      logic take;
      take = 1'b1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!hold_done && bytes_accepted >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else begin
            if (pattern_left == 0) begin
               stall_style  = $urandom_range(0, 3);
               pattern_left = $urandom_range(16, 96);
            end
            pattern_left--;
            case (stall_style)
               0: take = 1'b1;                            // always ready
               1: take = ($urandom_range(0, 1) == 1);     // coin flip
               2: take = (pattern_left % 4 == 0);         // one cycle in four
               default: take = ($urandom_range(0, 9) != 0);
            endcase
         end
         rsp_ready <= take;
      end
   end

   // ------------------------------------------------------------------
   // monitor: each accepted word against the oldest one owed
   // ------------------------------------------------------------------
   int          error_count   = 0;
   int          words_checked = 0;
   logic [28:0] kinds_seen    = '0;

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         if (rsp_token_kind <= KIND_ERROR) kinds_seen[rsp_token_kind] = 1'b1;
         if (tokens_due.size() == 0) begin
            $error("token word with none expected: kind %0d offset %0d length %0d",
                   rsp_token_kind, rsp_token_offset, rsp_token_length);
            error_count++;
         end else begin
            want = tokens_due.pop_front();
            if (rsp_token_kind !== want.kind) begin
               $error("token_kind mismatch: expected %0d, got %0d", want.kind, rsp_token_kind);
               error_count++;
            end
            if (rsp_token_offset !== want.offset) begin
               $error("token_offset mismatch: expected %0d, got %0d",
                      want.offset, rsp_token_offset);
               error_count++;
            end
            if (rsp_token_length !== want.length) begin
               $error("token_length mismatch: expected %0d, got %0d",
                      want.length, rsp_token_length);
               error_count++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run mismatch: expected %0d, got %0d", want.last, rsp_last_of_run);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // watchdog: nothing moving on either side for too long ends the run
   // ------------------------------------------------------------------
   int quiet_cycles = 0;
   int input_stalls = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_ready) input_stalls++;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // sequence: reset, let the driver drain the texts, wait out the block, report
   // ------------------------------------------------------------------
   initial begin
      reset_lexer();
      build_stimulus();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (bytes_accepted < total_bytes) @(posedge clock);
      while (tokens_due.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("ran %0d bytes in %0d texts, %0d token words checked, %0d of 29 kinds seen",
               bytes_accepted, texts_done, words_checked, $countones(kinds_seen));
      $display("receiver held off %0d cycles once; input stalled %0d cycles in all",
               HOLD_CYCLES, input_stalls);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
